// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned BIT_CNT_W     = 4;
    localparam int unsigned WAIT_W        = 12;

    localparam logic [7:0]  TICKS_PER_US_RST = 8'd1;
    localparam logic [7:0]  ACK_TRIES_RST    = 8'd10;

    typedef enum logic {
        CFG_TICKS_PER_US = 1'b0,
        CFG_ACK_TRIES    = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_ST_A      = 4'd1,
        PH_ST_B      = 4'd2,
        PH_SP_A      = 4'd3,
        PH_SP_B      = 4'd4,
        PH_W_LOW     = 4'd5,
        PH_W_HIGH    = 4'd6,
        PH_ACK_SETUP = 4'd7,
        PH_ACK_POLL  = 4'd8,
        PH_R_LOW     = 4'd9,
        PH_R_HIGH    = 4'd10,
        PH_A_LOW     = 4'd11,
        PH_A_HIGH    = 4'd12
    } t_phase;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] wdata;
        logic [1:0] ack_mode;
        logic       sda;
    } t_item;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] read_byte;
        logic       ack_ok;
        logic       rejected;
    } t_result;

endpackage

// ===== rtl/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts tick words, decodes the opcode and queues them for the engine.
// ----------------------------------------------------------------------------
module i2cm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  logic [2:0]     i_op,
    input  logic [7:0]     i_wdata,
    input  logic [1:0]     i_ack_mode,
    input  logic           i_sda_sample,
    output logic           o_item_valid,
    output i2cm_pkg::t_item o_item,
    input  logic           i_item_take
);
    import i2cm_pkg::*;

    t_item      r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;
    t_cmd       w_cmd;
    logic       w_wr;
    logic       w_rd;

    always_comb begin
        unique case (i_op)
            CMD_START:                  w_cmd = CMD_START;
            CMD_STOP:                   w_cmd = CMD_STOP;
            CMD_WRITE:                  w_cmd = CMD_WRITE;
            CMD_READ:                   w_cmd = CMD_READ;
            default:                    w_cmd = CMD_NONE;
        endcase
    end

    assign full         = (r_count == 2'd2);
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_mem[r_rptr];
    assign w_wr         = push && !full;
    assign w_rd         = i_item_take && o_item_valid;

    always_comb begin
        n_wptr  = w_wr ? ~r_wptr : r_wptr;
        n_rptr  = w_rd ? ~r_rptr : r_rptr;
        n_count = r_count + {1'b0, w_wr} - {1'b0, w_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= '{cmd: w_cmd, wdata: i_wdata, ack_mode: i_ack_mode,
                               sda: i_sda_sample};
        end
    end

endmodule

// ===== rtl/i2cm_engine.sv =====
// ----------------------------------------------------------------------------
// i2cm_engine
// Phase sequencer: one word per cycle unless outq is full, one result per word.
// ----------------------------------------------------------------------------
module i2cm_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_ticks_per_us,
    input  logic [7:0]        i_ack_tries,
    input  logic              i_item_valid,
    input  i2cm_pkg::t_item   i_item,
    output logic              o_item_take,
    input  logic              i_out_full,
    output i2cm_pkg::t_result o_res
);
    import i2cm_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [BIT_CNT_W-1:0]   r_bit, n_bit;
    logic [WAIT_W-1:0]      r_wait, n_wait;
    logic [7:0]             r_try, n_try;
    logic [7:0]             r_shift, n_shift;
    logic [1:0]             r_choice, n_choice;
    logic                   r_scl, n_scl;
    logic                   r_sda, n_sda;
    logic                   r_ack, n_ack;
    logic [7:0]             r_read, n_read;
    logic                   w_done;
    logic                   w_rej;
    logic                   w_take;
    logic [WAIT_W-1:0]      w_t1, w_t2, w_t5, w_t10;
    logic [WAIT_W-1:0]      w_dec;
    logic [7:0]             w_try_inc;
    logic [BIT_CNT_W-1:0]   w_bit_inc;
    logic [7:0]             w_shift_in;

    assign w_take      = i_item_valid && !i_out_full;
    assign o_item_take = w_take;

    // delay lengths: 2, 5 and 10 us
    assign w_t1  = (i_ticks_per_us == 8'd0) ? WAIT_W'(1) : WAIT_W'(i_ticks_per_us);
    assign w_t2  = w_t1 << 1;
    assign w_t5  = (w_t1 << 2) + w_t1;
    assign w_t10 = w_t5 << 1;

    assign w_dec      = r_wait - WAIT_W'(1);
    assign w_try_inc  = r_try + 8'd1;
    assign w_bit_inc  = r_bit + BIT_CNT_W'(1);
    assign w_shift_in = {r_shift[6:0], i_item.sda};

    always_comb begin
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_wait   = r_wait;
        n_try    = r_try;
        n_shift  = r_shift;
        n_choice = r_choice;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_ack    = r_ack;
        n_read   = r_read;
        w_done   = 1'b0;
        w_rej    = 1'b0;
        if (r_phase != PH_IDLE) begin
            w_rej  = (i_item.cmd != CMD_NONE);
            n_wait = w_dec;
            if (w_dec == '0) begin
                unique case (r_phase)
                    PH_ST_A: begin
                        n_sda   = 1'b0;
                        n_wait  = w_t5;
                        n_phase = PH_ST_B;
                    end
                    PH_SP_A: begin
                        n_sda   = 1'b1;
                        n_wait  = w_t2;
                        n_phase = PH_SP_B;
                    end
                    PH_W_LOW: begin
                        n_sda   = r_shift[7];
                        n_shift = {r_shift[6:0], 1'b0};
                        n_scl   = 1'b1;
                        n_bit   = w_bit_inc;
                        n_wait  = w_t2;
                        n_phase = PH_W_HIGH;
                    end
                    PH_W_HIGH: begin
                        n_scl = 1'b0;
                        if (r_bit < BIT_CNT_W'(BITS_PER_BYTE)) begin
                            n_wait  = w_t2;
                            n_phase = PH_W_LOW;
                        end else begin
                            n_sda   = 1'b1;
                            n_try   = 8'd0;
                            n_wait  = w_t5;
                            n_phase = PH_ACK_SETUP;
                        end
                    end
                    PH_ACK_SETUP, PH_ACK_POLL: begin
                        n_scl = 1'b1;
                        if (!i_item.sda) begin
                            n_scl  = 1'b0;
                            n_ack  = 1'b1;
                            w_done = 1'b1;
                        end else begin
                            n_try = w_try_inc;
                            if (w_try_inc == i_ack_tries) begin
                                n_scl  = 1'b0;
                                n_ack  = 1'b0;
                                w_done = 1'b1;
                            end else begin
                                n_wait  = w_t10;
                                n_phase = PH_ACK_POLL;
                            end
                        end
                    end
                    PH_R_LOW: begin
                        n_scl   = 1'b1;
                        n_wait  = w_t2;
                        n_phase = PH_R_HIGH;
                    end
                    PH_R_HIGH: begin
                        n_shift = w_shift_in;
                        n_bit   = w_bit_inc;
                        if (w_bit_inc < BIT_CNT_W'(BITS_PER_BYTE)) begin
                            n_scl   = 1'b0;
                            n_wait  = w_t2;
                            n_phase = PH_R_LOW;
                        end else begin
                            n_read = w_shift_in;
                            if (r_choice <= 2'd1) begin
                                n_scl   = 1'b0;
                                n_sda   = r_choice[0];
                                n_wait  = w_t2;
                                n_phase = PH_A_LOW;
                            end else begin
                                w_done = 1'b1;
                            end
                        end
                    end
                    PH_A_LOW: begin
                        n_scl   = 1'b1;
                        n_wait  = w_t5;
                        n_phase = PH_A_HIGH;
                    end
                    default: begin
                        w_done = 1'b1;
                    end
                endcase
                if (w_done) begin
                    n_phase = PH_IDLE;
                    n_wait  = '0;
                end
            end
        end else if (i_item.cmd != CMD_NONE) begin
            n_bit = '0;
            n_try = 8'd0;
            unique case (i_item.cmd)
                CMD_START: begin
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                    n_wait  = w_t5;
                    n_phase = PH_ST_A;
                end
                CMD_STOP: begin
                    n_sda   = 1'b0;
                    n_scl   = 1'b1;
                    n_wait  = w_t2;
                    n_phase = PH_SP_A;
                end
                CMD_WRITE: begin
                    n_shift = i_item.wdata;
                    n_scl   = 1'b0;
                    n_wait  = w_t2;
                    n_phase = PH_W_LOW;
                end
                default: begin
                    n_shift  = 8'd0;
                    n_choice = i_item.ack_mode;
                    n_sda    = 1'b1;
                    n_scl    = 1'b0;
                    n_wait   = w_t2;
                    n_phase  = PH_R_LOW;
                end
            endcase
        end
    end

    assign o_res = '{scl: n_scl, sda: n_sda, busy: (n_phase != PH_IDLE), done: w_done,
                     read_byte: n_read, ack_ok: n_ack, rejected: w_rej};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_bit    <= '0;
            r_wait   <= '0;
            r_try    <= 8'd0;
            r_shift  <= 8'd0;
            r_choice <= 2'd0;
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
            r_ack    <= 1'b0;
            r_read   <= 8'd0;
        end else if (w_take) begin
            r_phase  <= n_phase;
            r_bit    <= n_bit;
            r_wait   <= n_wait;
            r_try    <= n_try;
            r_shift  <= n_shift;
            r_choice <= n_choice;
            r_scl    <= n_scl;
            r_sda    <= n_sda;
            r_ack    <= n_ack;
            r_read   <= n_read;
        end
    end

    a_busy_wait_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_wait != '0))
        else $error("wait counter zero while busy");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_done) |=> (r_phase == PH_IDLE))
        else $error("phase not idle after done");

    a_reject_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && o_res.rejected) |-> (r_phase != PH_IDLE))
        else $error("command rejected while idle");

endmodule

// ===== rtl/i2cm_outq.sv =====
// ----------------------------------------------------------------------------
// i2cm_outq
// Two-word result queue between the engine and the result ports.
// ----------------------------------------------------------------------------
module i2cm_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  i2cm_pkg::t_result i_res,
    output logic              o_full,
    output logic              empty,
    input  logic              pop,
    output i2cm_pkg::t_result o_res
);
    import i2cm_pkg::*;

    t_result    r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;
    logic       w_wr;
    logic       w_rd;

    assign o_full = (r_count == 2'd2);
    assign empty  = (r_count == 2'd0);
    assign o_res  = r_mem[r_rptr];
    assign w_wr   = i_wr && !o_full;
    assign w_rd   = pop && !empty;

    always_comb begin
        n_wptr  = w_wr ? ~r_wptr : r_wptr;
        n_rptr  = w_rd ? ~r_rptr : r_rptr;
        n_count = r_count + {1'b0, w_wr} - {1'b0, w_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_res;
        end
    end

endmodule

// ===== rtl/i2c_master_bit_engine_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_top
// I2C master bit engine: tick words in, one pin/status word out per tick.
//
//   channel   handshake             payload
//   ------    --------------------  ----------------------------------------
//   input     push / full           op, wdata, ack_mode, sda_sample
//   result    empty / pop           scl/sda level, busy, done, read_byte,
//                                   ack_ok, rejected
//   config    APB psel/penable      ticks_per_us @0x0, ack_tries @0x4
//
// One word per clock sustained while results are popped. Each word waits in
// the input queue until the sequencer takes it; its result enters the result
// queue in the same cycle, from which it can be popped.
// Reset is synchronous; sequencer idle, SCL/SDA released, queues empty.
// Both sides stall independently through two-word queues; full rises only
// when the input queue holds two words the sequencer could not take.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_wdata,
    input  logic [1:0]  i_ack_mode,
    input  logic        i_sda_sample,
    output logic        empty,
    input  logic        pop,
    output logic        o_scl_level,
    output logic        o_sda_level,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_byte,
    output logic        o_ack_ok,
    output logic        o_rejected,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2cm_pkg::*;

    logic [7:0] r_ticks_per_us;
    logic [7:0] r_ack_tries;
    logic       w_cfg_wr;
    t_cfg_idx   w_cfg_idx;
    logic       w_item_valid;
    t_item      w_item;
    logic       w_item_take;
    logic       w_out_full;
    t_result    w_eng_res;
    t_result    w_out_res;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = t_cfg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_us <= TICKS_PER_US_RST;
            r_ack_tries    <= ACK_TRIES_RST;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                CFG_TICKS_PER_US: r_ticks_per_us <= pwdata[7:0];
                default:          r_ack_tries    <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            CFG_TICKS_PER_US: prdata = {24'd0, r_ticks_per_us};
            default:          prdata = {24'd0, r_ack_tries};
        endcase
    end

    i2cm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_op         (i_op),
        .i_wdata      (i_wdata),
        .i_ack_mode   (i_ack_mode),
        .i_sda_sample (i_sda_sample),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_take  (w_item_take)
    );

    i2cm_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ticks_per_us (r_ticks_per_us),
        .i_ack_tries    (r_ack_tries),
        .i_item_valid   (w_item_valid),
        .i_item         (w_item),
        .o_item_take    (w_item_take),
        .i_out_full     (w_out_full),
        .o_res          (w_eng_res)
    );

    i2cm_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_item_take),
        .i_res   (w_eng_res),
        .o_full  (w_out_full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (w_out_res)
    );

    assign o_scl_level = w_out_res.scl;
    assign o_sda_level = w_out_res.sda;
    assign o_busy_res  = w_out_res.busy;
    assign o_done_res  = w_out_res.done;
    assign o_read_byte = w_out_res.read_byte;
    assign o_ack_ok    = w_out_res.ack_ok;
    assign o_rejected  = w_out_res.rejected;

endmodule
